[hdl/usmg_pkg.sv]
// Package for the UV sphere mesh generator: sizes, codes, command type and the
// CORDIC arctangent table. No dependencies; every other file but usmg_checker imports it.
package usmg_pkg;

    localparam int MAX_RINGS     = 64;
    localparam int MAX_SLICES    = 64;
    localparam int ANGLE_BITS    = 16;
    localparam int CNT_W         = 7;
    localparam int IDX_W         = 13;
    localparam int POS_W         = 16;
    localparam int RAD_W         = 15;
    localparam int CFG_IDX_W     = 2;
    localparam int CORDIC_STEPS  = 28;
    localparam int CORDIC_X0     = 652032874;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS      = 2'd0,
        CFG_RING_COUNT  = 2'd1,
        CFG_SLICE_COUNT = 2'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        PH_TOP,
        PH_RING,
        PH_BOTTOM,
        PH_TOPFAN,
        PH_QUAD,
        PH_BOTFAN
    } t_phase;

    typedef enum logic [1:0] {
        CMD_POLE_TOP,
        CMD_POLE_BOTTOM,
        CMD_RING,
        CMD_TRI
    } t_cmd_kind;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_ROT,
        BK_MUL1,
        BK_MUL2
    } t_bk_state;

    typedef struct packed {
        t_cmd_kind        kind;
        logic [CNT_W-1:0] ring_num;
        logic [CNT_W:0]   ring_den;
        logic [CNT_W-1:0] slc_num;
        logic [CNT_W-1:0] slc_den;
        logic [IDX_W-1:0] corner_a;
        logic [IDX_W-1:0] corner_b;
        logic [IDX_W-1:0] corner_c;
        logic             final_item;
    } t_cmd;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000029;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

[hdl/usmg_front.sv]
// Mesh walker: tracks the walk position and turns each accepted transaction
// into a command for the back end. Depends on usmg_pkg.
module usmg_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr,
    input  logic                    i_accept,
    input  logic                    i_restart,
    input  logic [6:0]              i_ring_count,
    input  logic [6:0]              i_slice_count,
    output usmg_pkg::t_cmd          o_cmd
);
    import usmg_pkg::*;

    t_phase             r_phase, n_phase;
    logic [CNT_W-1:0]   r_ring, n_ring;
    logic [CNT_W-1:0]   r_slice, n_slice;
    logic               r_half, n_half;

    t_phase             cur_phase;
    logic [CNT_W-1:0]   cur_ring;
    logic [CNT_W-1:0]   cur_slice;
    logic               cur_half;
    logic [CNT_W-1:0]   eff_r;
    logic [CNT_W-1:0]   eff_s;
    logic [IDX_W-1:0]   k13, s13, r13, ring13, p13, c13, v13;
    logic               k_inner;

    always_comb begin
        eff_r = i_ring_count;
        if (i_ring_count < CNT_W'(1)) eff_r = CNT_W'(1);
        if (i_ring_count > CNT_W'(MAX_RINGS)) eff_r = CNT_W'(MAX_RINGS);
        eff_s = i_slice_count;
        if (i_slice_count < CNT_W'(3)) eff_s = CNT_W'(3);
        if (i_slice_count > CNT_W'(MAX_SLICES)) eff_s = CNT_W'(MAX_SLICES);
    end

    assign cur_phase = i_restart ? PH_TOP : r_phase;
    assign cur_ring  = i_restart ? '0 : r_ring;
    assign cur_slice = i_restart ? '0 : r_slice;
    assign cur_half  = i_restart ? 1'b0 : r_half;

    assign k13     = IDX_W'(cur_slice);
    assign s13     = IDX_W'(eff_s);
    assign r13     = IDX_W'(eff_r);
    assign ring13  = IDX_W'(cur_ring);
    assign p13     = IDX_W'(1) + IDX_W'(ring13 * s13);
    assign c13     = p13 + s13;
    assign v13     = IDX_W'(r13 * s13) + IDX_W'(2);
    assign k_inner = (k13 + IDX_W'(1)) < s13;

    always_comb begin
        n_phase = cur_phase;
        n_ring  = cur_ring;
        n_slice = cur_slice;
        n_half  = cur_half;
        unique case (cur_phase)
            PH_TOP: begin
                n_phase = PH_RING;
                n_ring  = '0;
                n_slice = '0;
                n_half  = 1'b0;
            end
            PH_RING: begin
                n_slice = cur_slice + CNT_W'(1);
                if (k13 + IDX_W'(1) >= s13) begin
                    n_slice = '0;
                    n_ring  = cur_ring + CNT_W'(1);
                    if (ring13 + IDX_W'(1) >= r13) begin
                        n_ring  = '0;
                        n_phase = PH_BOTTOM;
                    end
                end
            end
            PH_BOTTOM: n_phase = PH_TOPFAN;
            PH_TOPFAN: begin
                n_slice = cur_slice + CNT_W'(1);
                if (k13 + IDX_W'(1) >= s13) begin
                    n_slice = '0;
                    n_phase = (eff_r >= CNT_W'(2)) ? PH_QUAD : PH_BOTFAN;
                end
            end
            PH_QUAD: begin
                n_half = ~cur_half;
                if (cur_half) begin
                    n_slice = cur_slice + CNT_W'(1);
                    if (k13 + IDX_W'(1) >= s13) begin
                        n_slice = '0;
                        n_ring  = cur_ring + CNT_W'(1);
                        if (ring13 + IDX_W'(2) >= r13) begin
                            n_ring  = '0;
                            n_phase = PH_BOTFAN;
                        end
                    end
                end
            end
            PH_BOTFAN: begin
                if (k_inner) begin
                    n_slice = cur_slice + CNT_W'(1);
                end else begin
                    n_phase = PH_TOP;
                    n_ring  = '0;
                    n_slice = '0;
                    n_half  = 1'b0;
                end
            end
            default: n_phase = PH_TOP;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.kind     = CMD_TRI;
        o_cmd.ring_num = cur_ring + CNT_W'(1);
        o_cmd.ring_den = {eff_r, 1'b0} + (CNT_W+1)'(2);
        o_cmd.slc_num  = eff_s - cur_slice;
        o_cmd.slc_den  = eff_s;
        unique case (cur_phase)
            PH_TOP:    o_cmd.kind = CMD_POLE_TOP;
            PH_RING:   o_cmd.kind = CMD_RING;
            PH_BOTTOM: o_cmd.kind = CMD_POLE_BOTTOM;
            PH_TOPFAN: begin
                if (k_inner) begin
                    o_cmd.corner_a = k13 + IDX_W'(2);
                    o_cmd.corner_c = k13 + IDX_W'(1);
                end else begin
                    o_cmd.corner_a = IDX_W'(1);
                    o_cmd.corner_c = s13;
                end
            end
            PH_QUAD: begin
                if (k_inner) begin
                    if (!cur_half) begin
                        o_cmd.corner_a = p13 + k13;
                        o_cmd.corner_b = c13 + k13;
                        o_cmd.corner_c = p13 + k13 + IDX_W'(1);
                    end else begin
                        o_cmd.corner_a = c13 + k13 + IDX_W'(1);
                        o_cmd.corner_b = p13 + k13 + IDX_W'(1);
                        o_cmd.corner_c = c13 + k13;
                    end
                end else begin
                    if (!cur_half) begin
                        o_cmd.corner_a = p13;
                        o_cmd.corner_b = p13 + s13 - IDX_W'(1);
                        o_cmd.corner_c = c13 + s13 - IDX_W'(1);
                    end else begin
                        o_cmd.corner_a = c13;
                        o_cmd.corner_b = p13;
                        o_cmd.corner_c = c13 + s13 - IDX_W'(1);
                    end
                end
            end
            PH_BOTFAN: begin
                if (k_inner) begin
                    o_cmd.corner_a = v13 - s13 + k13 - IDX_W'(1);
                    o_cmd.corner_b = v13 - IDX_W'(1);
                    o_cmd.corner_c = v13 - s13 + k13;
                end else begin
                    o_cmd.corner_a = v13 - IDX_W'(1) - s13;
                    o_cmd.corner_b = v13 - IDX_W'(2);
                    o_cmd.corner_c = v13 - IDX_W'(1);
                    o_cmd.final_item = 1'b1;
                end
            end
            default: o_cmd.kind = CMD_POLE_TOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr) begin
            r_phase <= PH_TOP;
            r_ring  <= '0;
            r_slice <= '0;
            r_half  <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_ring  <= n_ring;
            r_slice <= n_slice;
            r_half  <= n_half;
        end
    end

endmodule

[hdl/usmg_cmd_queue.sv]
// Two-entry command queue between the mesh walker and the vertex engine.
// Depends on usmg_pkg.
module usmg_cmd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  usmg_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output usmg_pkg::t_cmd  o_cmd
);
    import usmg_pkg::*;

    logic [1:0] r_count;
    t_cmd       r_head;
    t_cmd       r_tail;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else if (i_push && !i_pop) begin
            r_count <= r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            r_count <= r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && i_pop) begin
            if (r_count == 2'd1) begin
                r_head <= i_cmd;
            end else begin
                r_head <= r_tail;
                r_tail <= i_cmd;
            end
        end else if (i_push) begin
            if (r_count == 2'd0) r_head <= i_cmd;
            else r_tail <= i_cmd;
        end else if (i_pop) begin
            r_head <= r_tail;
        end
    end

endmodule

[hdl/usmg_back.sv]
// Vertex engine and result register: angle divider, shared CORDIC and the
// scaling multipliers for ring vertices; poles and triangles pass straight on.
// Depends on usmg_pkg.
module usmg_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [14:0]             i_radius,
    input  logic                    i_cmd_valid,
    input  usmg_pkg::t_cmd          i_cmd,
    output logic                    o_cmd_pop,
    input  logic                    i_pop,
    output logic                    o_empty,
    output logic                    o_kind,
    output logic signed [15:0]      o_pos_x,
    output logic signed [15:0]      o_pos_y,
    output logic signed [15:0]      o_pos_z,
    output logic [12:0]             o_corner_a,
    output logic [12:0]             o_corner_b,
    output logic [12:0]             o_corner_c,
    output logic                    o_final_item
);
    import usmg_pkg::*;

    localparam int DIV_W = ANGLE_BITS + CNT_W;

    function automatic logic signed [POS_W-1:0] to_q14(input logic signed [33:0] v);
        logic signed [33:0] t;
        t = (v + 34'sd32768) >>> 16;
        if (t > 34'sd16384) t = 34'sd16384;
        if (t < -34'sd16384) t = -34'sd16384;
        return POS_W'(t);
    endfunction

    function automatic logic signed [POS_W-1:0] sat16(input logic signed [47:0] v);
        logic signed [47:0] t;
        t = v;
        if (t > 48'sd32767) t = 48'sd32767;
        if (t < -48'sd32768) t = -48'sd32768;
        return POS_W'(t);
    endfunction

    function automatic logic [DIV_W-1:0] dvd_init(input logic [CNT_W-1:0] num,
                                                  input logic [CNT_W:0] den);
        return (DIV_W'(num) << ANGLE_BITS) + DIV_W'(den >> 1);
    endfunction

    t_bk_state                 r_state, n_state;
    logic                      r_second;
    logic [4:0]                r_cnt;
    logic [DIV_W-1:0]          r_dvd;
    logic [CNT_W:0]            r_rem;
    logic [CNT_W:0]            r_den;
    logic [CNT_W-1:0]          r_azi_num;
    logic [CNT_W-1:0]          r_azi_den;
    logic [1:0]                r_quad;
    logic signed [33:0]        r_x, r_y;
    logic signed [31:0]        r_z;
    logic signed [POS_W-1:0]   r_st, r_ct, r_sp, r_cp;
    logic signed [31:0]        r_p1, r_py;

    logic                      r_out_valid;
    logic                      r_kind;
    logic signed [POS_W-1:0]   r_pos_x, r_pos_y, r_pos_z;
    logic [IDX_W-1:0]          r_corner_a, r_corner_b, r_corner_c;
    logic                      r_final;

    logic                      imm_load;
    logic                      fin_load;
    logic [CNT_W+1:0]          rem_sh;
    logic                      q_bit;
    logic [CNT_W+1:0]          rem_nx;
    logic [ANGLE_BITS-1:0]     angle_fin;
    logic                      div_last, rot_last;
    logic signed [33:0]        xs, ys, x_nx, y_nx;
    logic signed [31:0]        at, z_nx;
    logic signed [POS_W-1:0]   qx, qy, f_sn, f_cs;
    logic signed [15:0]        rad_s;
    logic signed [47:0]        prod_x, prod_z, res_x, res_y, res_z;

    assign rem_sh    = {r_rem, r_dvd[DIV_W-1]};
    assign q_bit     = rem_sh >= {1'b0, r_den};
    assign rem_nx    = q_bit ? rem_sh - {1'b0, r_den} : rem_sh;
    assign angle_fin = {r_dvd[ANGLE_BITS-2:0], q_bit};
    assign div_last  = (r_cnt == 5'(DIV_W - 1));
    assign rot_last  = (r_cnt == 5'(CORDIC_STEPS - 1));

    assign xs   = r_x >>> r_cnt;
    assign ys   = r_y >>> r_cnt;
    assign at   = signed'(atan_turn(r_cnt));
    assign x_nx = r_z[31] ? r_x + ys : r_x - ys;
    assign y_nx = r_z[31] ? r_y - xs : r_y + xs;
    assign z_nx = r_z[31] ? r_z + at : r_z - at;
    assign qx   = to_q14(x_nx);
    assign qy   = to_q14(y_nx);

    always_comb begin
        case (r_quad)
            2'd0:    begin f_sn = qy;  f_cs = qx;  end
            2'd1:    begin f_sn = qx;  f_cs = -qy; end
            2'd2:    begin f_sn = -qy; f_cs = -qx; end
            default: begin f_sn = -qx; f_cs = qy;  end
        endcase
    end

    assign rad_s  = signed'({1'b0, i_radius});
    assign prod_x = 48'(r_p1) * 48'(r_cp);
    assign prod_z = 48'(r_p1) * 48'(r_sp);
    assign res_x  = (prod_x + 48'sd134217728) >>> 28;
    assign res_z  = (prod_z + 48'sd134217728) >>> 28;
    assign res_y  = (48'(r_py) + 48'sd8192) >>> 14;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid && !r_out_valid && i_cmd.kind == CMD_RING) n_state = BK_DIV;
            end
            BK_DIV:  if (div_last) n_state = BK_ROT;
            BK_ROT:  if (rot_last) n_state = r_second ? BK_MUL1 : BK_DIV;
            BK_MUL1: n_state = BK_MUL2;
            BK_MUL2: n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop = (r_state == BK_IDLE) && i_cmd_valid && !r_out_valid;
        imm_load  = o_cmd_pop && (i_cmd.kind != CMD_RING);
        fin_load  = (r_state == BK_MUL2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            BK_IDLE: begin
                r_dvd     <= dvd_init(i_cmd.ring_num, i_cmd.ring_den);
                r_den     <= i_cmd.ring_den;
                r_rem     <= '0;
                r_cnt     <= '0;
                r_second  <= 1'b0;
                r_azi_num <= i_cmd.slc_num;
                r_azi_den <= i_cmd.slc_den;
            end
            BK_DIV: begin
                r_rem <= rem_nx[CNT_W:0];
                r_dvd <= {r_dvd[DIV_W-2:0], q_bit};
                r_cnt <= div_last ? 5'd0 : r_cnt + 5'd1;
                if (div_last) begin
                    r_quad <= angle_fin[ANGLE_BITS-1 -: 2];
                    r_x    <= 34'(CORDIC_X0);
                    r_y    <= '0;
                    r_z    <= signed'(32'(angle_fin[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS));
                end
            end
            BK_ROT: begin
                r_x   <= x_nx;
                r_y   <= y_nx;
                r_z   <= z_nx;
                r_cnt <= rot_last ? 5'd0 : r_cnt + 5'd1;
                if (rot_last) begin
                    if (!r_second) begin
                        r_st     <= f_sn;
                        r_ct     <= f_cs;
                        r_second <= 1'b1;
                        r_dvd    <= dvd_init(r_azi_num, {1'b0, r_azi_den});
                        r_den    <= {1'b0, r_azi_den};
                        r_rem    <= '0;
                    end else begin
                        r_sp <= f_sn;
                        r_cp <= f_cs;
                    end
                end
            end
            BK_MUL1: begin
                r_p1 <= 32'(rad_s) * 32'(r_st);
                r_py <= 32'(rad_s) * 32'(r_ct);
            end
            BK_MUL2: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (imm_load || fin_load) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_load) begin
            r_kind     <= 1'b0;
            r_pos_x    <= sat16(res_x);
            r_pos_y    <= sat16(res_y);
            r_pos_z    <= sat16(res_z);
            r_corner_a <= '0;
            r_corner_b <= '0;
            r_corner_c <= '0;
            r_final    <= 1'b0;
        end else if (imm_load) begin
            r_kind     <= (i_cmd.kind == CMD_TRI);
            r_pos_x    <= '0;
            r_pos_z    <= '0;
            r_corner_a <= i_cmd.corner_a;
            r_corner_b <= i_cmd.corner_b;
            r_corner_c <= i_cmd.corner_c;
            r_final    <= i_cmd.final_item;
            case (i_cmd.kind)
                CMD_POLE_TOP:    r_pos_y <= rad_s;
                CMD_POLE_BOTTOM: r_pos_y <= -rad_s;
                default:         r_pos_y <= '0;
            endcase
        end
    end

    assign o_empty      = ~r_out_valid;
    assign o_kind       = r_kind;
    assign o_pos_x      = r_pos_x;
    assign o_pos_y      = r_pos_y;
    assign o_pos_z      = r_pos_z;
    assign o_corner_a   = r_corner_a;
    assign o_corner_b   = r_corner_b;
    assign o_corner_c   = r_corner_c;
    assign o_final_item = r_final;

endmodule

[hdl/uv_sphere_mesh_generator_core.sv]
// UV sphere mesh generator, top level: configuration registers, mesh walker,
// command queue and vertex engine. Depends on usmg_pkg, usmg_front,
// usmg_cmd_queue and usmg_back.
//
// Usage: each transaction on the input queue (i_push while o_full is low)
// produces exactly one result on the output queue, read with i_pop while
// o_empty is low. i_restart = 1 restarts the walk at the top pole vertex.
// Results come in walk order: top pole, ring vertices, bottom pole, then the
// triangles; o_final_item marks the last triangle, after which the walk wraps.
// The configuration channel (i_cfg_valid, o_cfg_ready always high) writes
// radius, ring count and slice count; each write restarts the walk. Writes must
// be made only while no result is outstanding; the block does not enforce it.
// Poles and triangles pass through the command queue and the result register.
// A ring vertex takes the command load, then two 23-step angle divisions and
// two 28-step CORDIC rotations, which share one divider and one rotator, then
// two multiply stages. The engine takes a new command only once the result
// register has been popped, so each command waits in the queue until the
// result before it has been read.
// A two-entry command queue lets the walker accept transactions while the
// engine works; when the result register is not popped, the engine holds and
// o_full rises once the queue fills. Reset empties both queues and returns
// the walk and the registers to their reset values.
module uv_sphere_mesh_generator_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic                i_restart,
    output logic                o_empty,
    input  logic                i_pop,
    output logic                o_kind,
    output logic signed [15:0]  o_pos_x,
    output logic signed [15:0]  o_pos_y,
    output logic signed [15:0]  o_pos_z,
    output logic [12:0]         o_corner_a,
    output logic [12:0]         o_corner_b,
    output logic [12:0]         o_corner_c,
    output logic                o_final_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [14:0]         i_cfg_data
);
    import usmg_pkg::*;

    logic [RAD_W-1:0] r_radius;
    logic [CNT_W-1:0] r_ring_count;
    logic [CNT_W-1:0] r_slice_count;
    logic             cfg_wr;
    logic             in_accept;
    logic             q_full, q_valid, q_pop;
    t_cmd             front_cmd, q_cmd;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_push && !q_full;
    assign o_full      = q_full;

    always_comb begin
        cfg_wr = 1'b0;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RADIUS, CFG_RING_COUNT, CFG_SLICE_COUNT: cfg_wr = 1'b1;
                default:                                      cfg_wr = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius      <= RAD_W'(256);
            r_ring_count  <= CNT_W'(8);
            r_slice_count <= CNT_W'(16);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RADIUS:      r_radius      <= i_cfg_data;
                CFG_RING_COUNT:  r_ring_count  <= i_cfg_data[CNT_W-1:0];
                CFG_SLICE_COUNT: r_slice_count <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    usmg_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr      (cfg_wr),
        .i_accept      (in_accept),
        .i_restart     (i_restart),
        .i_ring_count  (r_ring_count),
        .i_slice_count (r_slice_count),
        .o_cmd         (front_cmd)
    );

    usmg_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    usmg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_radius     (r_radius),
        .i_cmd_valid  (q_valid),
        .i_cmd        (q_cmd),
        .o_cmd_pop    (q_pop),
        .i_pop        (i_pop),
        .o_empty      (o_empty),
        .o_kind       (o_kind),
        .o_pos_x      (o_pos_x),
        .o_pos_y      (o_pos_y),
        .o_pos_z      (o_pos_z),
        .o_corner_a   (o_corner_a),
        .o_corner_b   (o_corner_b),
        .o_corner_c   (o_corner_c),
        .o_final_item (o_final_item)
    );

endmodule

[hdl/usmg_checker.sv]
// Port-level checks for the UV sphere mesh generator and the bind that
// attaches them to uv_sphere_mesh_generator_core. No package dependency.
module usmg_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_empty,
    input logic                i_pop,
    input logic                o_kind,
    input logic signed [15:0]  o_pos_x,
    input logic signed [15:0]  o_pos_y,
    input logic signed [15:0]  o_pos_z,
    input logic [12:0]         o_corner_a,
    input logic [12:0]         o_corner_b,
    input logic [12:0]         o_corner_c,
    input logic                o_final_item
);

    a_empty_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("Result queue is not empty after reset.");

    a_vertex_no_corners: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_kind) |-> (o_corner_a == 13'd0 && o_corner_b == 13'd0
                                   && o_corner_c == 13'd0 && !o_final_item))
        else $error("Vertex transaction carries triangle fields.");

    a_triangle_no_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_kind) |-> (o_pos_x == 16'sd0 && o_pos_y == 16'sd0
                                  && o_pos_z == 16'sd0))
        else $error("Triangle transaction carries a position.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_kind) && $stable(o_pos_y)
                                  && $stable(o_corner_a)))
        else $error("Waiting result changed while stalled.");

endmodule

bind uv_sphere_mesh_generator_core usmg_checker u_usmg_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_empty      (o_empty),
    .i_pop        (i_pop),
    .o_kind       (o_kind),
    .o_pos_x      (o_pos_x),
    .o_pos_y      (o_pos_y),
    .o_pos_z      (o_pos_z),
    .o_corner_a   (o_corner_a),
    .o_corner_b   (o_corner_b),
    .o_corner_c   (o_corner_c),
    .o_final_item (o_final_item)
);
